### rtl/core/trle_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// trle_pkg
// Shared types and constants of the transparency run-length scanline encoder.
// ============================================================================
package trle_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;   // run length field of a header byte
  localparam int CHUNK_BYTES = 8;
  localparam int CNT_W       = 3;   // fill level of a chunk under assembly, 0..7
  localparam int OUT_CNT_W   = 4;   // byte_count field, 1..8
  localparam int MAX_RUN_DEF = 127;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  localparam logic [BYTE_W-1:0] TRANSP_FLAG = 8'h80;
  localparam logic [BYTE_W-1:0] TERM_BYTE   = 8'h00;

  // One queue entry holds all the work caused by one pixel: an optional flush of
  // the previous run, an optional flush of the run the pixel belongs to, and an
  // optional line terminator.
  typedef struct packed {
    logic             a_valid;
    logic             a_opq;
    logic [LEN_W-1:0] a_len;
    logic             b_valid;
    logic             b_opq;
    logic [LEN_W-1:0] b_len;
    logic             term;
    logic             has_opq;
  } trle_cmd_t;

  typedef struct packed {
    logic              en;
    logic [LEN_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } trle_wr_t;

  typedef struct packed {
    logic entry_done;
    logic done_opq;
  } trle_bk_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HEAD,
    BK_LIT,
    BK_TERM
  } bk_state_t;

endpackage

### rtl/core/trle_front.sv
`timescale 1ns / 1ps
// ============================================================================
// trle_front
// Accepts pixels, tracks the open run and turns each pixel that closes a run into one queue entry.
// ============================================================================
module trle_front
  import trle_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_pixel,
  input  logic              in_line_end,
  input  logic              fifo_full,
  output logic              push,
  output trle_cmd_t         push_cmd,
  output trle_wr_t          mem_wr,
  input  trle_bk_stat_t     bk_stat
);

  logic             run_opq_r, run_opq_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic             opq_busy_r, opq_busy_nxt;

  logic             accept;
  logic             opaque;
  logic [LEN_W-1:0] len1;
  logic [LEN_W-1:0] new_len;
  logic             full_run;

  // Literal store is shared with the back end, so no new pixel is taken while
  // an opaque flush is still queued or draining.
  assign in_ready = !fifo_full && !opq_busy_r;
  assign accept   = in_valid && in_ready;
  assign opaque   = (in_pixel != '0);

  always_comb begin
    push_cmd         = '0;
    push_cmd.a_valid = (run_len_r != '0) && (run_opq_r != opaque);
    push_cmd.a_opq   = run_opq_r;
    push_cmd.a_len   = run_len_r;

    len1     = push_cmd.a_valid ? '0 : run_len_r;
    new_len  = len1 + LEN_W'(1);
    full_run = (new_len == LEN_W'(MAX_RUN));

    push_cmd.b_valid = full_run || in_line_end;
    push_cmd.b_opq   = opaque;
    push_cmd.b_len   = new_len;
    push_cmd.term    = in_line_end;
    push_cmd.has_opq = (push_cmd.a_valid && push_cmd.a_opq) ||
                       (push_cmd.b_valid && push_cmd.b_opq);

    push = accept && (push_cmd.a_valid || push_cmd.b_valid || push_cmd.term);

    mem_wr.en   = accept && opaque;
    mem_wr.addr = len1;
    mem_wr.data = in_pixel;

    run_len_nxt  = run_len_r;
    run_opq_nxt  = run_opq_r;
    opq_busy_nxt = opq_busy_r;
    if (accept) begin
      if (push_cmd.b_valid) begin
        run_len_nxt = '0;
        run_opq_nxt = 1'b0;
      end else begin
        run_len_nxt = new_len;
        run_opq_nxt = opaque;
      end
    end
    if (push && push_cmd.has_opq) begin
      opq_busy_nxt = 1'b1;
    end else if (bk_stat.done_opq) begin
      opq_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r  <= '0;
      run_opq_r  <= 1'b0;
      opq_busy_r <= 1'b0;
    end else begin
      run_len_r  <= run_len_nxt;
      run_opq_r  <= run_opq_nxt;
      opq_busy_r <= opq_busy_nxt;
    end
  end

endmodule

### rtl/core/trle_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// trle_fifo
// Short queue of run commands between the front end and the byte generator.
// ============================================================================
module trle_fifo
  import trle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  trle_cmd_t push_cmd,
  input  logic      pop,
  output trle_cmd_t head,
  output logic      full,
  output logic      empty
);

  trle_cmd_t          slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   fill_r, fill_nxt;

  assign full  = (fill_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (FIFO_AW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

### rtl/core/trle_back.sv
`timescale 1ns / 1ps
// ============================================================================
// trle_back
// Executes queued run commands one byte per cycle, pausing when a chunk closes on a full
// output register, and packs bytes into chunks of up to eight. Holds the open opaque run's literal store.
// ============================================================================
module trle_back
  import trle_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_empty,
  output logic                          pop,
  input  trle_cmd_t                     head,
  input  trle_wr_t                      mem_wr,
  output trle_bk_stat_t                 stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CHUNK_BYTES*BYTE_W-1:0] out_bytes,
  output logic [OUT_CNT_W-1:0]          out_count,
  output logic                          out_last,
  output logic                          out_line_done
);

  localparam int IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  bk_state_t        state_r, state_nxt;
  trle_cmd_t        cur_r, cur_nxt;
  logic             seg_r, seg_nxt;          // 0: first flush, 1: second flush
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [BYTE_W-1:0] store [MAX_RUN];
  logic [BYTE_W-1:0] rd_data_r;

  logic [BYTE_W-1:0] asm_r [CHUNK_BYTES];
  logic [BYTE_W-1:0] asm_nxt [CHUNK_BYTES];
  logic [CNT_W-1:0]  asm_cnt_r, asm_cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [CHUNK_BYTES*BYTE_W-1:0] out_bytes_r, out_bytes_nxt;
  logic [OUT_CNT_W-1:0]          out_cnt_r, out_cnt_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_done_r, out_done_nxt;

  logic             seg_opq;
  logic [LEN_W-1:0] seg_len;
  logic             more_b;
  logic             lit_end;
  logic             emitting;
  logic             last_byte;
  logic             closing;
  logic             out_free;
  logic             adv;
  logic [BYTE_W-1:0] byte_val;

  assign seg_opq  = seg_r ? cur_r.b_opq : cur_r.a_opq;
  assign seg_len  = seg_r ? cur_r.b_len : cur_r.a_len;
  assign more_b   = !seg_r && cur_r.b_valid;
  assign lit_end  = ((LEN_W'(idx_r) + LEN_W'(1)) == seg_len);
  assign out_free = !out_valid_r || out_ready;

  // Next state of the byte sequencer.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    seg_nxt   = seg_r;
    idx_nxt   = idx_r;
    case (state_r)
      BK_IDLE: begin
        if (!fifo_empty) begin
          cur_nxt = head;
          if (head.a_valid) begin
            state_nxt = BK_HEAD;
            seg_nxt   = 1'b0;
          end else if (head.b_valid) begin
            state_nxt = BK_HEAD;
            seg_nxt   = 1'b1;
          end else begin
            state_nxt = BK_TERM;
          end
        end
      end
      BK_HEAD, BK_LIT: begin
        if (adv) begin
          if (state_r == BK_HEAD && seg_opq) begin
            state_nxt = BK_LIT;
            idx_nxt   = '0;
          end else if (state_r == BK_LIT && !lit_end) begin
            idx_nxt = idx_r + IDX_W'(1);
          end else if (more_b) begin
            state_nxt = BK_HEAD;
            seg_nxt   = 1'b1;
          end else if (cur_r.term) begin
            state_nxt = BK_TERM;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_TERM: begin
        if (adv) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Sequencer outputs: the byte of this cycle and whether it ends the entry.
  always_comb begin
    pop       = 1'b0;
    emitting  = 1'b0;
    last_byte = 1'b0;
    byte_val  = TERM_BYTE;
    case (state_r)
      BK_IDLE: begin
        pop = !fifo_empty;
      end
      BK_HEAD: begin
        emitting  = 1'b1;
        byte_val  = seg_opq ? {1'b0, seg_len} : (TRANSP_FLAG | {1'b0, seg_len});
        last_byte = !seg_opq && !more_b && !cur_r.term;
      end
      BK_LIT: begin
        emitting  = 1'b1;
        byte_val  = rd_data_r;
        last_byte = lit_end && !more_b && !cur_r.term;
      end
      BK_TERM: begin
        emitting  = 1'b1;
        byte_val  = TERM_BYTE;
        last_byte = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    closing         = (asm_cnt_r == CNT_W'(CHUNK_BYTES - 1)) || last_byte;
    adv             = emitting && (!closing || out_free);
    stat.entry_done = adv && last_byte;
    stat.done_opq   = adv && last_byte && cur_r.has_opq;
  end

  // Chunk assembly and the output register.
  always_comb begin
    for (int j = 0; j < CHUNK_BYTES; j++) begin
      asm_nxt[j] = asm_r[j];
    end
    asm_cnt_nxt   = asm_cnt_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_bytes_nxt = out_bytes_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    if (adv) begin
      if (closing) begin
        for (int j = 0; j < CHUNK_BYTES; j++) begin
          if (CNT_W'(j) < asm_cnt_r) begin
            out_bytes_nxt[j*BYTE_W +: BYTE_W] = asm_r[j];
          end else if (CNT_W'(j) == asm_cnt_r) begin
            out_bytes_nxt[j*BYTE_W +: BYTE_W] = byte_val;
          end else begin
            out_bytes_nxt[j*BYTE_W +: BYTE_W] = '0;
          end
        end
        out_valid_nxt = 1'b1;
        out_cnt_nxt   = OUT_CNT_W'(asm_cnt_r) + OUT_CNT_W'(1);
        out_last_nxt  = last_byte;
        out_done_nxt  = last_byte && cur_r.term;
        asm_cnt_nxt   = '0;
      end else begin
        asm_nxt[asm_cnt_r] = byte_val;
        asm_cnt_nxt        = asm_cnt_r + CNT_W'(1);
      end
    end
  end

  // Literal store: written by the front end, read one entry ahead of use.
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      store[mem_wr.addr[IDX_W-1:0]] <= mem_wr.data;
    end
    rd_data_r <= store[idx_nxt];
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    idx_r       <= idx_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
    for (int j = 0; j < CHUNK_BYTES; j++) begin
      asm_r[j] <= asm_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      seg_r       <= 1'b0;
      asm_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      asm_cnt_r   <= asm_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bytes     = out_bytes_r;
  assign out_count     = out_cnt_r;
  assign out_last      = out_last_r;
  assign out_line_done = out_done_r;

endmodule

### rtl/core/transparent_rle_scanline_encoder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// transparent_rle_scanline_encoder_core
// Run-length encoder for 8-bit palette scanlines with a transparent color.
// ============================================================================
// Usage:
// - The in_ stream carries one pixel per request; in_tlast marks the last pixel
//   of a scanline. Pixel value 0 is transparent.
// - The out_ stream carries chunks of up to eight encoded bytes. out_tlast is
//   set on the final chunk caused by one pixel; out_tuser is set on the chunk
//   that holds the line terminator.
// - A pixel that only extends a run is taken every cycle while in_tready is high and produces nothing.
// - A pixel that closes runs is turned into one queue entry. The byte generator
//   loads an entry from the queue and then emits one byte per cycle, pausing
//   only when a chunk closes while the receiver has not yet taken the last one.
// - The literal store has a single write and a single read port; while an
//   opaque run is queued or being drained from it, in_tready stays low. Earlier
//   queued entries and receiver stalls keep it low for longer.
// - A four-entry command queue and the output register let the input side keep
//   running while the receiver stalls, until the queue fills.
// - Synchronous reset (rst_n low) empties the queue, drops any pending chunk
//   and starts with no open run. The literal store needs no clearing.
// ============================================================================
module transparent_rle_scanline_encoder_core
  import trle_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] byte_0..byte_7, [67:64] byte_count, rest 0
  output logic        out_tlast,  // chunk_last
  output logic        out_tuser   // line_done
);

  logic                          fifo_full;
  logic                          fifo_empty;
  logic                          push;
  logic                          pop;
  trle_cmd_t                     push_cmd;
  trle_cmd_t                     head_cmd;
  trle_wr_t                      mem_wr;
  trle_bk_stat_t                 bk_stat;
  logic [CHUNK_BYTES*BYTE_W-1:0] chunk_bytes;
  logic [OUT_CNT_W-1:0]          chunk_count;

  trle_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_pixel    (in_tdata),
    .in_line_end (in_tlast),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .mem_wr      (mem_wr),
    .bk_stat     (bk_stat)
  );

  trle_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  trle_back #(
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_empty    (fifo_empty),
    .pop           (pop),
    .head          (head_cmd),
    .mem_wr        (mem_wr),
    .stat          (bk_stat),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_bytes     (chunk_bytes),
    .out_count     (chunk_count),
    .out_last      (out_tlast),
    .out_line_done (out_tuser)
  );

  assign out_tdata = {4'b0000, chunk_count, chunk_bytes};

endmodule

### rtl/core/trle_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// trle_checker
// Port-level checks of the encoder's output stream.
// ============================================================================
module trle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled chunk must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output chunk changed while stalled");

  // Byte count lies between one and eight.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[67:64] != 4'd0) && (out_tdata[67:64] <= 4'd8))
    else $error("byte count out of range");

  // Only the final chunk of a pixel may be partly filled.
  a_full_chunks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[67:64] == 4'd8)
    else $error("non-final chunk is not full");

  // The terminator always ends the output of its pixel.
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("line terminator not on final chunk");

  // Reset drops any pending chunk.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind transparent_rle_scanline_encoder_core trle_checker u_trle_checker (.*);

### tb/trle_chunk_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// trle_chunk_checker
// Watches both streams of the scanline encoder, predicts every output chunk
// from the accepted pixels and compares each delivered chunk field by field.
// ============================================================================
module trle_chunk_checker
  import trle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned chunks_seen,
  output int unsigned terms_seen
);

  localparam int RUN_CAP = MAX_RUN_DEF;

  typedef struct packed {
    logic [CHUNK_BYTES*BYTE_W-1:0] bytes;
    logic [OUT_CNT_W-1:0]          count;
    logic                          last;
    logic                          done;
  } chunk_t;

  chunk_t            chunk_q[$];
  logic [BYTE_W-1:0] byte_stream[$];

  // Encoder state as the predictor sees it.
  logic              run_opq;
  int unsigned       run_len;
  logic [BYTE_W-1:0] lit_store[RUN_CAP];

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Emits the open run, if any, into the byte stream and empties it.
  function automatic void close_run();
    if (run_len == 0) return;
    if (run_opq) begin
      byte_stream.push_back(BYTE_W'(run_len));
      for (int i = 0; i < run_len; i++) begin
        byte_stream.push_back(lit_store[i]);
      end
    end else begin
      byte_stream.push_back(TRANSP_FLAG | BYTE_W'(run_len));
    end
    run_len = 0;
    run_opq = 1'b0;
  endfunction

  function automatic void encode_pixel(input logic [7:0] pix, input logic line_end);
    logic        opq;
    int unsigned n;
    int unsigned n_chunks;
    int unsigned cnt;
    chunk_t      c;
    byte_stream.delete();
    opq = (pix != 8'd0);
    if (run_len != 0 && run_opq != opq) close_run();
    if (run_len == 0) run_opq = opq;
    if (opq) lit_store[run_len] = pix;
    run_len++;
    if (run_len >= RUN_CAP) close_run();
    if (line_end) begin
      close_run();
      byte_stream.push_back(TERM_BYTE);
    end
    n        = byte_stream.size();
    n_chunks = (n + CHUNK_BYTES - 1) / CHUNK_BYTES;
    for (int k = 0; k < n_chunks; k++) begin
      cnt = n - k * CHUNK_BYTES;
      if (cnt > CHUNK_BYTES) cnt = CHUNK_BYTES;
      c.bytes = '0;
      for (int j = 0; j < cnt; j++) begin
        c.bytes[j*BYTE_W +: BYTE_W] = byte_stream[k*CHUNK_BYTES + j];
      end
      c.count = OUT_CNT_W'(cnt);
      c.last  = (k == n_chunks - 1);
      c.done  = c.last && line_end;
      chunk_q.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    chunk_t want;
    if (!rst_n) begin
      run_len     = 0;
      run_opq     = 1'b0;
      mismatches  = 0;
      chunks_seen = 0;
      terms_seen  = 0;
      chunk_q.delete();
    end else begin
      // A chunk can never leave in the same cycle as the pixel that causes it,
      // so predicting before comparing is safe.
      if (in_tvalid && in_tready) encode_pixel(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (chunk_q.size() == 0) begin
          note_mismatch($sformatf("chunk with no prediction, tdata %h", out_tdata));
        end else begin
          want = chunk_q.pop_front();
          for (int j = 0; j < CHUNK_BYTES; j++) begin
            if (out_tdata[j*BYTE_W +: BYTE_W] !== want.bytes[j*BYTE_W +: BYTE_W]) begin
              note_mismatch($sformatf("chunk %0d byte_%0d: want %02h got %02h",
                chunks_seen, j, want.bytes[j*BYTE_W +: BYTE_W],
                out_tdata[j*BYTE_W +: BYTE_W]));
            end
          end
          if (out_tdata[67:64] !== want.count) begin
            note_mismatch($sformatf("chunk %0d byte_count: want %0d got %0d",
              chunks_seen, want.count, out_tdata[67:64]));
          end
          if (out_tdata[71:68] !== 4'd0) begin
            note_mismatch($sformatf("chunk %0d pad bits not zero: %h",
              chunks_seen, out_tdata[71:68]));
          end
          if (out_tlast !== want.last) begin
            note_mismatch($sformatf("chunk %0d chunk_last: want %0b got %0b",
              chunks_seen, want.last, out_tlast));
          end
          if (out_tuser !== want.done) begin
            note_mismatch($sformatf("chunk %0d line_done: want %0b got %0b",
              chunks_seen, want.done, out_tuser));
          end
        end
        chunks_seen++;
        if (out_tuser === 1'b1) terms_seen++;
      end
    end
    pending = chunk_q.size();
  end

endmodule

### tb/tb_transparent_rle_scanline_encoder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_transparent_rle_scanline_encoder_core
// Streams scanlines of palette pixels into the run-length encoder and lets the
// chunk checker compare every encoded chunk against its own prediction.
// ============================================================================
// A short directed part hits lone pixels, kind changes, an opaque run that
// spills into a second chunk and the extreme pixel values. The random part
// builds scanlines out of runs of random kind and length, including one
// opaque and one transparent run long enough to hit the length cap. Both
// sides idle at random, and the receiver twice stalls for a long stretch so
// that the command queue fills and the input side is pushed back.
// ============================================================================
module tb_transparent_rle_scanline_encoder_core;
  import trle_pkg::*;

  localparam int          RUN_CAP      = MAX_RUN_DEF;
  localparam int unsigned RANDOM_PIX   = 50;        // pixels in short random runs
  localparam int unsigned HOLD_CYCLES  = 300;       // long receiver stall
  localparam int unsigned SETTLE       = 160;       // worst drain of one request
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // Directed pixels: bit 8 is the line end flag, bits 7:0 the pixel.
  localparam logic [8:0] DIRECTED [21] = '{
    9'h100,                                           // lone transparent line
    9'h1FF,                                           // lone opaque line
    9'h001, 9'h080, 9'h000, 9'h000, 9'h17F,           // kind changes
    9'h001, 9'h002, 9'h004, 9'h008, 9'h010, 9'h020,   // walking one, spills
    9'h040, 9'h080, 9'h100,                           // into a second chunk
    9'h000, 9'h000, 9'h100,                           // transparent line end
    9'h0AA, 9'h155                                    // alternating bits
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] pixel
  logic        in_tlast;    // line_end
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;   // [63:0] byte_0..byte_7, [67:64] byte_count, rest 0
  logic        out_tlast;   // chunk_last
  logic        out_tuser;   // line_done

  int unsigned mismatches;
  int unsigned pending;
  int unsigned chunks_seen;
  int unsigned terms_seen;

  int unsigned pixels_sent;
  int unsigned lines_sent;
  int unsigned cycles = 0;
  int unsigned hold_reqs;   // long receiver stalls asked for so far

  transparent_rle_scanline_encoder_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  trle_chunk_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .pending     (pending),
    .chunks_seen (chunks_seen),
    .terms_seen  (terms_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d chunks still due", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Gap lengths are mostly short, now and then a long pause.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver. It alternates between stretches where it is always ready and
  // stretches with random stalls. When the stimulus asks for a hold, this
  // process counts the long stall down on its own while the sender keeps going.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned holds_taken;
    bit          eager;
    stall_left  = 0;
    hold_left   = 0;
    mode_left   = 0;
    holds_taken = 0;
    eager       = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(32, 96);
        eager     = ($urandom_range(0, 2) == 0);
      end else begin
        mode_left--;
      end
      if (holds_taken != hold_reqs) begin
        holds_taken = hold_reqs;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!eager && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one pixel and returns at the edge where the request is taken.
  // An idle gap, if any, follows with junk on the data lines.
  task automatic send_pixel(input logic [7:0] pix, input logic line_end, input bit no_gap);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tlast  <= line_end;
    do @(posedge clk); while (in_tready !== 1'b1);
    pixels_sent++;
    if (line_end) lines_sent++;
    gap = 0;
    if (!no_gap && $urandom_range(0, 99) >= 60) gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tlast  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Main stimulus and verdict.
  initial begin
    int unsigned short_pix;
    int unsigned run_n;
    bit          opq_kind;
    bit          fast;
    bit          long_run;
    bit          long_opq_done;
    bit          long_tr_done;
    bit          second_hold_done;
    logic [7:0]  pix;
    logic        line_end;

    pixels_sent      = 0;
    lines_sent       = 0;
    hold_reqs        = 0;
    short_pix        = 0;
    long_opq_done    = 1'b0;
    long_tr_done     = 1'b0;
    second_hold_done = 1'b0;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tlast  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_pixel(DIRECTED[i][7:0], DIRECTED[i][8], 1'b0);
    end

    // The first long stall lands right as the random scanlines start.
    hold_reqs++;

    // Random scanlines, built run by run. Runs of the same kind back to back
    // simply merge, which the encoder must handle as one run.
    while (short_pix < RANDOM_PIX || !long_opq_done || !long_tr_done) begin
      long_run = 1'b0;
      if (!long_opq_done && short_pix >= 15) begin
        opq_kind      = 1'b1;
        run_n         = $urandom_range(RUN_CAP, RUN_CAP + 3);
        long_opq_done = 1'b1;
        long_run      = 1'b1;
      end else if (!long_tr_done && short_pix >= 30) begin
        opq_kind     = 1'b0;
        run_n        = $urandom_range(RUN_CAP, RUN_CAP + 3);
        long_tr_done = 1'b1;
        long_run     = 1'b1;
      end else begin
        opq_kind = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
          0:             run_n = $urandom_range(13, 40);
          1, 2, 3, 4:    run_n = $urandom_range(5, 12);
          default:       run_n = $urandom_range(1, 4);
        endcase
        short_pix += run_n;
      end
      if (!second_hold_done && short_pix >= 40) begin
        second_hold_done = 1'b1;
        hold_reqs++;
      end
      // Some runs go back to back with no idle cycles at all.
      fast = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run_n; i++) begin
        pix = opq_kind ? 8'($urandom_range(1, 255)) : 8'd0;
        // A long run keeps its line open so that it reaches the cap.
        if (i == run_n - 1) line_end = ($urandom_range(0, 3) == 0);
        else                line_end = !long_run && ($urandom_range(0, 49) == 0);
        send_pixel(pix, line_end, fast);
      end
    end

    // Close the last scanline so its terminator is checked too.
    send_pixel(8'd0, 1'b1, 1'b1);

    if (in_tvalid) in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d pixels in %0d scanlines, with runs of both kinds past the %0d cap.",
      pixels_sent, lines_sent, RUN_CAP);
    $display("Compared %0d chunks, %0d holding a line terminator; %0d mismatches.",
      chunks_seen, terms_seen, mismatches);
    if (pending != 0) begin
      $display("%0d predicted chunks never arrived", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### transparent_rle_scanline_encoder_core.f
rtl/core/trle_pkg.sv
rtl/core/trle_front.sv
rtl/core/trle_fifo.sv
rtl/core/trle_back.sv
rtl/core/transparent_rle_scanline_encoder_core.sv
rtl/core/trle_checker.sv
tb/trle_chunk_checker.sv
tb/tb_transparent_rle_scanline_encoder_core.sv
